// ===== rtl/mmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmbd_pkg
// Types, codes and address-map constants shared by the memory map decoder.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  localparam int unsigned MainDepth = 16384;  // video RAM + work RAM
  localparam int unsigned HighDepth = 512;    // 0xFE00-0xFFFF page
  localparam int unsigned MainAw    = $clog2(MainDepth);
  localparam int unsigned HighAw    = $clog2(HighDepth);

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_IRQ   = 2'd2;

  localparam logic [1:0] ROUTE_INT = 2'd0;
  localparam logic [1:0] ROUTE_ROM = 2'd1;
  localparam logic [1:0] ROUTE_RAM = 2'd2;

  localparam logic [7:0]        OPEN_BUS   = 8'hFF;
  // interrupt flag byte: io offset 0x0F, io page starts at 0x100 of high page
  localparam logic [HighAw-1:0] IRQ_FLAG_IDX = HighAw'(9'h10F);

  typedef enum logic [2:0] {
    TGT_CART_ROM,
    TGT_CART_RAM,
    TGT_MAIN,
    TGT_HIGH,
    TGT_OPEN
  } tgt_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_FF,
    RD_MAIN,
    RD_HIGH
  } rd_src_e;

  typedef struct packed {
    tgt_e              tgt;
    logic [MainAw-1:0] main_idx;
    logic [HighAw-1:0] high_idx;
  } dec_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  route;
    logic [15:0] fwd_address;
    logic        fwd_write;
    logic [7:0]  fwd_data;
  } res_t;

endpackage

// ===== rtl/mmbd_ram.sv =====
// ----------------------------------------------------------------------------
// mmbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mmbd_decode.sv =====
// ----------------------------------------------------------------------------
// mmbd_decode
// Address decode of the 16-bit bus into target region and memory indexes.
// ----------------------------------------------------------------------------
module mmbd_decode import mmbd_pkg::*; (
  input  logic [15:0] address_i,
  output dec_t        dec_o
);

  always_comb begin
    dec_o.main_idx = {address_i[14], address_i[12:0]};  // 0: video, 1: work/echo
    dec_o.high_idx = address_i[HighAw-1:0];
    if (address_i <= 16'h7FFF) begin
      dec_o.tgt = TGT_CART_ROM;
    end else if (address_i <= 16'h9FFF) begin
      dec_o.tgt = TGT_MAIN;
    end else if (address_i <= 16'hBFFF) begin
      dec_o.tgt = TGT_CART_RAM;
    end else if (address_i <= 16'hFDFF) begin
      dec_o.tgt = TGT_MAIN;
    end else if (address_i <= 16'hFE9F) begin
      dec_o.tgt = TGT_HIGH;
    end else if (address_i <= 16'hFEFF) begin
      dec_o.tgt = TGT_OPEN;
    end else begin
      dec_o.tgt = TGT_HIGH;
    end
  end

endmodule

// ===== rtl/memory_map_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// memory_map_bus_decoder
// Byte bus decoder with internal video/work RAM, object RAM, I/O, high RAM.
// ----------------------------------------------------------------------------
// A read or write accepted on start returns its result on res_o with done_o
// high in the next cycle, and a new access can be taken every cycle while
// busy is low. An interrupt request also raises busy once it is accepted,
// since it reads, ORs and writes back the flag byte through the single write
// port of the high-page memory. After reset busy stays high while both
// memories are swept to zero; configuration writes are taken during that
// time. done_o cannot be held off: the read data is on res_o for that one
// cycle only.
module memory_map_bus_decoder import mmbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  dec_t dec;

  logic              cart_present_q;
  logic              clr_active_q;
  logic [MainAw-1:0] clr_idx_q;
  logic              done_q;
  logic              irq_q;
  rd_src_e           rd_src_q, rd_src_d;
  logic [1:0]        route_q, route_d;
  logic [15:0]       faddr_q, faddr_d;
  logic              fwr_q, fwr_d;
  logic [7:0]        fdata_q, fdata_d;
  logic [7:0]        mask_q;

  logic              accept;
  logic              main_we;
  logic [MainAw-1:0] main_waddr, main_raddr;
  logic [7:0]        main_wdata, main_rdata;
  logic              high_we;
  logic [HighAw-1:0] high_waddr, high_raddr;
  logic [7:0]        high_wdata, high_rdata;

  mmbd_decode u_decode (
    .address_i (req_i.address),
    .dec_o     (dec)
  );

  assign busy   = clr_active_q | irq_q;
  assign accept = start & ~busy;

  // result decode for the transfer being accepted
  always_comb begin
    rd_src_d = RD_ZERO;
    route_d  = ROUTE_INT;
    faddr_d  = '0;
    fwr_d    = 1'b0;
    fdata_d  = '0;
    if (req_i.req_type == REQ_READ || req_i.req_type == REQ_WRITE) begin
      unique case (dec.tgt)
        TGT_CART_ROM, TGT_CART_RAM: begin
          if (cart_present_q) begin
            route_d = (dec.tgt == TGT_CART_ROM) ? ROUTE_ROM : ROUTE_RAM;
            faddr_d = req_i.address;
            fwr_d   = (req_i.req_type == REQ_WRITE);
            fdata_d = (req_i.req_type == REQ_WRITE) ? req_i.write_data : 8'h00;
          end else if (req_i.req_type == REQ_READ) begin
            rd_src_d = RD_FF;
          end
        end
        TGT_MAIN: if (req_i.req_type == REQ_READ) rd_src_d = RD_MAIN;
        TGT_HIGH: if (req_i.req_type == REQ_READ) rd_src_d = RD_HIGH;
        TGT_OPEN: if (req_i.req_type == REQ_READ) rd_src_d = RD_FF;
        default:  rd_src_d = RD_ZERO;
      endcase
    end
  end

  // memory port control
  always_comb begin
    main_raddr = dec.main_idx;
    high_raddr = (req_i.req_type == REQ_IRQ) ? IRQ_FLAG_IDX : dec.high_idx;
    if (clr_active_q) begin
      main_we    = 1'b1;
      main_waddr = clr_idx_q;
      main_wdata = '0;
      high_we    = 1'b1;
      high_waddr = clr_idx_q[HighAw-1:0];
      high_wdata = '0;
    end else begin
      main_we    = accept && req_i.req_type == REQ_WRITE && dec.tgt == TGT_MAIN;
      main_waddr = dec.main_idx;
      main_wdata = req_i.write_data;
      if (irq_q) begin
        // write back the flag byte read in the previous cycle
        high_we    = 1'b1;
        high_waddr = IRQ_FLAG_IDX;
        high_wdata = high_rdata | mask_q;
      end else begin
        high_we    = accept && req_i.req_type == REQ_WRITE && dec.tgt == TGT_HIGH;
        high_waddr = dec.high_idx;
        high_wdata = req_i.write_data;
      end
    end
  end

  mmbd_ram #(.Width(8), .Depth(MainDepth)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .raddr_i (main_raddr),
    .rdata_o (main_rdata)
  );

  mmbd_ram #(.Width(8), .Depth(HighDepth)) u_high_ram (
    .clk_i   (clk_i),
    .we_i    (high_we),
    .waddr_i (high_waddr),
    .wdata_i (high_wdata),
    .raddr_i (high_raddr),
    .rdata_o (high_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_present_q <= 1'b0;
      clr_active_q   <= 1'b1;
      clr_idx_q      <= '0;
      done_q         <= 1'b0;
      irq_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cart_present_q <= cfg_wdata_i;
      end
      if (clr_active_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (&clr_idx_q) begin
          clr_active_q <= 1'b0;
        end
      end
      done_q <= accept;
      irq_q  <= accept && req_i.req_type == REQ_IRQ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_src_q <= rd_src_d;
      route_q  <= route_d;
      faddr_q  <= faddr_d;
      fwr_q    <= fwr_d;
      fdata_q  <= fdata_d;
      mask_q   <= req_i.write_data;
    end
  end

  always_comb begin
    case (rd_src_q)
      RD_FF:   res_o.read_data = OPEN_BUS;
      RD_MAIN: res_o.read_data = main_rdata;
      RD_HIGH: res_o.read_data = high_rdata;
      default: res_o.read_data = 8'h00;
    endcase
    res_o.route       = route_q;
    res_o.fwd_address = faddr_q;
    res_o.fwd_write   = fwr_q;
    res_o.fwd_data    = fdata_q;
  end

  assign done_o = done_q;

endmodule
